>>> rtl/lgg_pkg.sv
// ----------------------------------------------------------------------------
// lgg_pkg
// Shared constants and row conversion helpers for the life grid generation
// step block.
// ----------------------------------------------------------------------------
`default_nettype none

package lgg_pkg;

    // default grid edge length
    localparam int GRID_SIZE_DEF = 8;

    // widest grid that the helpers support
    localparam int GRID_SIZE_MAX = 64;

    // neighbour counts of the life rule
    localparam logic [3:0] LIVE_BIRTH = 4'd3;
    localparam logic [3:0] LIVE_KEEP  = 4'd2;

    // input item kinds carried on tuser
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // starting pattern of rows 0..7, bit 7 is column 0
    localparam logic [7:0] START_ROWS [8] = '{
        8'b11000000, 8'b11000000, 8'b00000000, 8'b00000000,
        8'b00000000, 8'b00000010, 8'b00000110, 8'b00000101
    };

    // place columns 0..7 into a row word of g cells, msb of the word is column 0
    function automatic logic [GRID_SIZE_MAX-1:0] widen_row(input logic [7:0] bits8,
                                                           input int g);
        logic [GRID_SIZE_MAX-1:0] v;
        int c;
        v = '0;
        for (int i = 0; i < GRID_SIZE_MAX; i++) begin
            c = g - 1 - i;
            if (i < g && c < 8) begin
                v[i] = bits8[7-c];
            end
        end
        return v;
    endfunction

    // take columns 0..7 out of a row word of g cells, missing columns read dead
    function automatic logic [7:0] narrow_row(input logic [GRID_SIZE_MAX-1:0] w,
                                              input int g);
        logic [7:0] v;
        int c;
        v = '0;
        for (int j = 0; j < 8; j++) begin
            c = 7 - j;
            if (c < g) begin
                v[j] = w[g-1-c];
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/lgg_row_unit.sv
// ----------------------------------------------------------------------------
// lgg_row_unit
// Shared life rule unit: computes one new row from the old rows above, at and
// below it, with dead cells beyond the left and right edges.
// ----------------------------------------------------------------------------
`default_nettype none

module lgg_row_unit
    import lgg_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  wire logic [GRID_SIZE-1:0] i_above,
    input  wire logic [GRID_SIZE-1:0] i_cur,
    input  wire logic [GRID_SIZE-1:0] i_below,
    output logic      [GRID_SIZE-1:0] o_next
);

    // rows with a dead guard cell at each end
    logic [GRID_SIZE+1:0] w_up;
    logic [GRID_SIZE+1:0] w_mid;
    logic [GRID_SIZE+1:0] w_dn;

    assign w_up  = {1'b0, i_above, 1'b0};
    assign w_mid = {1'b0, i_cur,   1'b0};
    assign w_dn  = {1'b0, i_below, 1'b0};

    // one neighbour count and rule per cell
    for (genvar i = 0; i < GRID_SIZE; i++) begin : g_cell
        logic [3:0] w_count;

        assign w_count = 4'(w_up[i])  + 4'(w_up[i+1])  + 4'(w_up[i+2])
                       + 4'(w_mid[i])                  + 4'(w_mid[i+2])
                       + 4'(w_dn[i])  + 4'(w_dn[i+1])  + 4'(w_dn[i+2]);

        assign o_next[i] = (w_count == LIVE_BIRTH) ||
                           ((w_count == LIVE_KEEP) && i_cur[i]);
    end

endmodule

`default_nettype wire

>>> rtl/life_grid_generation_step.sv
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Conway life on a square grid with a dead border, with row loads and a
// row-by-row generation sweep.
// ----------------------------------------------------------------------------
// A load item (tuser = 0) writes one row and gives no output item; rows
// beyond the grid are ignored. An advance item (tuser = 1) runs a sweep over
// all GRID_SIZE rows: one shared row unit computes one new row per cycle
// when the sink takes rows, from the old row above, the row itself and the
// row below, while the grid rotates through a row shift line so that new rows
// take the place of old ones. Each new row leaves through an output register;
// after acceptance the first row passes the state register and then the
// output register. Back-pressure stalls the sweep. The block takes no item
// during a sweep. The grid comes out of reset holding the starting pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_generation_step
    import lgg_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // load_row[2:0], load_bits[10:3], zeros
    input  wire logic        i_s_tuser,   // func

    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata,   // out_row[2:0], out_bits[10:3], zeros
    output logic             o_m_tlast    // last
);

    localparam int CW = $clog2(GRID_SIZE);
    localparam logic [CW-1:0] STEP_LAST = CW'(GRID_SIZE - 1);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_step;
    logic                r_out_valid;
    logic [2:0]          r_out_row;
    logic [7:0]          r_out_bits;
    logic                r_out_last;

    logic [GRID_SIZE-1:0] r_grid [GRID_SIZE];
    logic [GRID_SIZE-1:0] r_prev;

    logic                 w_accept;
    logic                 w_fire;
    logic                 w_at_last;
    logic [2:0]           w_load_row;
    logic [7:0]           w_load_bits;
    logic [GRID_SIZE-1:0] w_load_word;
    logic [GRID_SIZE-1:0] w_below;
    logic [GRID_SIZE-1:0] w_next;

    // input item fields
    assign w_load_row  = i_s_tdata[2:0];
    assign w_load_bits = i_s_tdata[10:3];
    assign w_load_word = GRID_SIZE'(widen_row(w_load_bits, GRID_SIZE));

    // handshakes and sweep step
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_fire     = (r_state == S_RUN) && (!r_out_valid || i_m_tready);
    assign w_at_last  = (r_step == STEP_LAST);

    // row below the current one, dead past the bottom edge
    assign w_below = w_at_last ? '0 : r_grid[1 % GRID_SIZE];

    lgg_row_unit #(
        .GRID_SIZE (GRID_SIZE)
    ) u_row_unit (
        .i_above (r_prev),
        .i_cur   (r_grid[0]),
        .i_below (w_below),
        .o_next  (w_next)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_s_tuser == FUNC_ADVANCE) begin
                        r_state <= S_RUN;
                        r_step  <= '0;
                    end
                end
                S_RUN: begin
                    if (w_fire) begin
                        if (w_at_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_step <= r_step + CW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (w_fire) begin
            r_out_row  <= 3'(r_step);
            r_out_bits <= narrow_row(64'(w_next), GRID_SIZE);
            r_out_last <= w_at_last;
        end
    end

    // grid rows: reset pattern, row loads, rotation during a sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < GRID_SIZE; r++) begin
                r_grid[r] <= (r < 8) ?
                    GRID_SIZE'(widen_row(START_ROWS[r % 8], GRID_SIZE)) : '0;
            end
        end else if (w_fire) begin
            for (int r = 0; r < GRID_SIZE - 1; r++) begin
                r_grid[r] <= r_grid[r+1];
            end
            r_grid[GRID_SIZE-1] <= w_next;
        end else if (w_accept && i_s_tuser == FUNC_LOAD) begin
            for (int r = 0; r < GRID_SIZE; r++) begin
                if (32'(w_load_row) == r) begin
                    r_grid[r] <= w_load_word;
                end
            end
        end
    end

    // old copy of the row above the current one, dead above the top edge
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prev <= '0;
        end else if (w_fire) begin
            r_prev <= r_grid[0];
        end
    end

    // output item
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_bits, r_out_row};
    assign o_m_tlast  = r_out_last;

    // a held last row means the sweep is over or a new one has not yet stepped
    a_last_ends_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (r_state == S_IDLE || r_step == '0))
        else $error("last row held while sweep still running");

    // each step short of the last moves the row counter on by one
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_at_last) |=> (r_step == $past(r_step) + CW'(1)))
        else $error("row counter did not advance");

    // a step always leaves a row in the output register
    a_fire_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_m_tvalid)
        else $error("computed row lost");

    // no input item is taken during a sweep
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !(w_fire && w_at_last)) |=> !o_s_tready)
        else $error("input taken during sweep");

endmodule

`default_nettype wire
